[rtl/core/ps2dfr_pkg.sv]
// Shared types and constants for the PS/2 set-2 scan code deframer.
// No dependencies; imported by the decoder and the top level.
`default_nettype none

package ps2dfr_pkg;

  localparam logic [7:0] BYTE_E0    = 8'hE0;
  localparam logic [7:0] BYTE_E1    = 8'hE1;
  localparam logic [7:0] BYTE_F0    = 8'hF0;
  localparam logic [7:0] BYTE_PS_MK = 8'h12;
  localparam logic [7:0] BYTE_PS_BK = 8'h7C;
  localparam logic [7:0] BYTE_ACK   = 8'hFA;
  localparam logic [7:0] BYTE_CAPS  = 8'h58;
  localparam logic [7:0] BYTE_NUM   = 8'h77;
  localparam logic [7:0] BYTE_SCRL  = 8'h7E;

  localparam logic [2:0] LED_CAPS = 3'd4;
  localparam logic [2:0] LED_NUM  = 3'd2;
  localparam logic [2:0] LED_SCRL = 3'd1;

  localparam logic [3:0] LEN_PS_MAKE  = 4'd4;
  localparam logic [3:0] LEN_PS_BREAK = 4'd6;
  localparam logic [3:0] LEN_PAUSE    = 4'd8;

  typedef enum logic [2:0] {
    KIND_NORMAL  = 3'd0,
    KIND_EXT     = 3'd1,
    KIND_PRTSC   = 3'd2,
    KIND_PAUSE   = 3'd3,
    KIND_UNKNOWN = 3'd4
  } key_kind_t;

  typedef struct packed {
    key_kind_t   key_kind;
    logic [7:0]  key_byte;
    logic        pressed;
    logic [2:0]  lock_leds;
    logic        leds_changed;
    logic        last_of_run;
  } event_t;

  typedef struct packed {
    logic       prefix_e0;
    logic       prefix_e1;
    logic       release_seen;
    logic       printscreen_seen;
    logic [3:0] byte_count;
    logic [2:0] led_bits;
  } dfr_state_t;

endpackage

`default_nettype wire

[rtl/core/ps2dfr_if.sv]
// Valid/ready channels of the deframer: incoming scan bytes and outgoing key events.
// No dependencies.
`default_nettype none

interface ps2dfr_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface ps2dfr_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] key_kind;
  logic [7:0] key_byte;
  logic       pressed;
  logic [2:0] lock_leds;
  logic       leds_changed;
  logic       last_of_run;

  modport source (output valid, output key_kind, output key_byte, output pressed,
                  output lock_leds, output leds_changed, output last_of_run,
                  input ready);
  modport sink   (input valid, input key_kind, input key_byte, input pressed,
                  input lock_leds, input leds_changed, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/ps2dfr_decode.sv]
// Combinational step of the deframer: prefix tracking and code decode for one byte.
// Depends on ps2dfr_pkg.
`default_nettype none

module ps2dfr_decode (
  input  wire ps2dfr_pkg::dfr_state_t state,
  input  wire logic [7:0]             byte0,
  input  wire logic [7:0]             byte1,
  input  wire logic [7:0]             scan_byte,
  output ps2dfr_pkg::dfr_state_t      state_next,
  output logic [1:0]                  num_events,
  output ps2dfr_pkg::event_t          first_event
);
  import ps2dfr_pkg::*;

  logic [3:0] n;
  logic [7:0] b0;
  logic [7:0] b1;
  logic       free_prefix;
  logic       is_e0, is_e1, is_f0, is_ps_mk, is_ps_bk, hold;
  logic       extended, pause, normal;
  logic [7:0] norm_byte;
  logic [2:0] mask;

  assign n  = state.byte_count + 4'd1;
  // the current byte stands in for the store entry it is written to
  assign b0 = (state.byte_count[2:0] == 3'd0) ? scan_byte : byte0;
  assign b1 = (state.byte_count == 4'd1) ? scan_byte : byte1;

  assign free_prefix = !state.prefix_e1 && !state.prefix_e0 && !state.printscreen_seen;
  assign is_e0    = free_prefix && (scan_byte == BYTE_E0);
  assign is_e1    = free_prefix && (scan_byte == BYTE_E1);
  assign is_f0    = !state.release_seen && (scan_byte == BYTE_F0);
  assign is_ps_mk = !state.printscreen_seen && state.prefix_e0 &&
                    (scan_byte == BYTE_PS_MK) && !state.release_seen;
  assign is_ps_bk = !state.printscreen_seen && state.prefix_e0 &&
                    (scan_byte == BYTE_PS_BK) && state.release_seen;
  assign hold = (state.prefix_e1 && (n < LEN_PAUSE)) ||
                (state.printscreen_seen &&
                 ((state.release_seen && (n < LEN_PS_BREAK)) ||
                  (!state.release_seen && (n < LEN_PS_MAKE))));

  assign extended  = (n >= 4'd2) && (b0 == BYTE_E0);
  assign pause     = (n == LEN_PAUSE) && (b0 == BYTE_E1);
  assign normal    = (n == 4'd1) || ((n == 4'd2) && (b0 == BYTE_F0));
  assign norm_byte = (n == 4'd1) ? b0 : b1;

  always_comb begin
    mask = 3'd0;
    if (n != 4'd1) begin
      if (norm_byte == BYTE_CAPS) begin
        mask = LED_CAPS;
      end else if (norm_byte == BYTE_NUM) begin
        mask = LED_NUM;
      end else if (norm_byte == BYTE_SCRL) begin
        mask = LED_SCRL;
      end
    end
  end

  always_comb begin
    state_next  = state;
    num_events  = 2'd0;
    first_event = '{key_kind: KIND_UNKNOWN, key_byte: 8'd0, pressed: 1'b0,
                    lock_leds: state.led_bits, leds_changed: 1'b0, last_of_run: 1'b1};
    state_next.byte_count = n;
    if (is_e0) begin
      state_next.prefix_e0 = 1'b1;
    end else if (is_e1) begin
      state_next.prefix_e1 = 1'b1;
    end else if (is_f0) begin
      state_next.release_seen = 1'b1;
    end else if (is_ps_mk || is_ps_bk) begin
      state_next.printscreen_seen = 1'b1;
    end else if (!hold) begin
      // code complete: decode, then drop the count and all prefixes
      state_next.byte_count       = 4'd0;
      state_next.prefix_e0        = 1'b0;
      state_next.prefix_e1        = 1'b0;
      state_next.release_seen     = 1'b0;
      state_next.printscreen_seen = 1'b0;
      num_events = 2'd1;
      if (extended) begin
        if ((n == LEN_PS_MAKE) || (n == LEN_PS_BREAK)) begin
          first_event.key_kind = KIND_PRTSC;
          first_event.pressed  = (n == LEN_PS_MAKE);
        end else if ((n == 4'd3) && (b1 == BYTE_F0)) begin
          first_event.key_kind = KIND_EXT;
          first_event.key_byte = scan_byte;
        end else if (n == 4'd2) begin
          first_event.key_kind = KIND_EXT;
          first_event.key_byte = b1;
          first_event.pressed  = 1'b1;
        end else begin
          first_event.key_kind = KIND_EXT;
        end
      end else if (pause) begin
        num_events = 2'd2;
        first_event.key_kind    = KIND_PAUSE;
        first_event.pressed     = 1'b1;
        first_event.last_of_run = 1'b0;
      end else if (normal) begin
        if (norm_byte == BYTE_ACK) begin
          num_events = 2'd0;
        end else begin
          state_next.led_bits       = state.led_bits ^ mask;
          first_event.key_kind      = KIND_NORMAL;
          first_event.key_byte      = norm_byte;
          first_event.pressed       = (n == 4'd1);
          first_event.lock_leds     = state.led_bits ^ mask;
          first_event.leds_changed  = (mask != 3'd0);
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/ps2_set2_scancode_deframer.sv]
// PS/2 set-2 scan code deframer, top level.
// A key event is valid in the cycle after the byte that completes its code is accepted.
// Throughput: one scan byte per cycle while the event register is free or being read; the pause
// code holds the input while its second (release) event goes out of the single event register.
// Reset: rst (synchronous) clears prefixes, byte count, lock LEDs and the event valid flag.
// Depends on ps2dfr_pkg, ps2dfr_if and ps2dfr_decode.
`default_nettype none

module ps2_set2_scancode_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  ps2dfr_scan_if.sink      scan,
  ps2dfr_event_if.source   evt
);
  import ps2dfr_pkg::*;

  dfr_state_t state;
  dfr_state_t state_next;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [1:0] num_events;
  event_t     first_event;
  event_t     out_event;
  logic       out_valid;
  logic       pause_pending;
  logic       accept;
  logic       out_free;

  ps2dfr_decode u_decode (
    .state       (state),
    .byte0       (byte0),
    .byte1       (byte1),
    .scan_byte   (scan.scan_byte),
    .state_next  (state_next),
    .num_events  (num_events),
    .first_event (first_event)
  );

  assign out_free   = !out_valid || evt.ready;
  assign scan.ready = !pause_pending && out_free;
  assign accept     = scan.valid && scan.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= '0;
      out_valid     <= 1'b0;
      pause_pending <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
        if (num_events != 2'd0) begin
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
        pause_pending <= (num_events == 2'd2);
      end else if (out_free) begin
        // second pause beat takes the slot as the first one drains
        out_valid     <= pause_pending;
        pause_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (state.byte_count[2:0] == 3'd0) begin
        byte0 <= scan.scan_byte;
      end
      if (state.byte_count[2:0] == 3'd1) begin
        byte1 <= scan.scan_byte;
      end
      if (num_events != 2'd0) begin
        out_event <= first_event;
      end
    end else if (out_free && pause_pending) begin
      out_event <= '{key_kind: KIND_PAUSE, key_byte: 8'd0, pressed: 1'b0,
                     lock_leds: state.led_bits, leds_changed: 1'b0, last_of_run: 1'b1};
    end
  end

  assign evt.valid        = out_valid;
  assign evt.key_kind     = out_event.key_kind;
  assign evt.key_byte     = out_event.key_byte;
  assign evt.pressed      = out_event.pressed;
  assign evt.lock_leds    = out_event.lock_leds;
  assign evt.leds_changed = out_event.leds_changed;
  assign evt.last_of_run  = out_event.last_of_run;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the PS/2 set-2 scan code deframer.
// Depends on ps2dfr_pkg, ps2dfr_if and ps2_set2_scancode_deframer.

import ps2dfr_pkg::*;

// Predicts key events from accepted scan bytes and checks each event beat.
class key_event_board;
  event_t     due_events[$];
  int         errors;
  int         events_seen;
  int         pauses_seen;
  int         toggles_seen;

  bit         in_e0;
  bit         in_e1;
  bit         in_break;
  bit         in_prtsc;
  bit [3:0]   held;
  bit [7:0]   code[8];
  bit [2:0]   leds;

  function void push_event(key_kind_t kind, logic [7:0] kb, bit pr, bit chg, bit last);
    event_t e;
    e.key_kind     = kind;
    e.key_byte     = kb;
    e.pressed      = pr;
    e.lock_leds    = leds;
    e.leds_changed = chg;
    e.last_of_run  = last;
    due_events.push_back(e);
  endfunction

  function void decode_code(bit [3:0] n);
    bit         pr;
    bit [7:0]   kb;
    bit [2:0]   mask;
    if (n >= 2 && code[0] == BYTE_E0) begin
      if (n == LEN_PS_MAKE || n == LEN_PS_BREAK)
        push_event(KIND_PRTSC, 8'h00, n == LEN_PS_MAKE, 1'b0, 1'b1);
      else if (n == 3 && code[1] == BYTE_F0)
        push_event(KIND_EXT, code[2], 1'b0, 1'b0, 1'b1);
      else if (n == 2)
        push_event(KIND_EXT, code[1], 1'b1, 1'b0, 1'b1);
      else
        push_event(KIND_EXT, 8'h00, 1'b0, 1'b0, 1'b1);
    end else if (n == LEN_PAUSE && code[0] == BYTE_E1) begin
      push_event(KIND_PAUSE, 8'h00, 1'b1, 1'b0, 1'b0);
      push_event(KIND_PAUSE, 8'h00, 1'b0, 1'b0, 1'b1);
    end else if (n == 1 || (n == 2 && code[0] == BYTE_F0)) begin
      pr   = (n == 1);
      kb   = pr ? code[0] : code[1];
      mask = 3'd0;
      // ack bytes produce nothing at all
      if (kb != BYTE_ACK) begin
        if (!pr) begin
          case (kb)
            BYTE_CAPS: mask = LED_CAPS;
            BYTE_NUM:  mask = LED_NUM;
            BYTE_SCRL: mask = LED_SCRL;
            default:   mask = 3'd0;
          endcase
        end
        leds = leds ^ mask;
        push_event(KIND_NORMAL, kb, pr, mask != 3'd0, 1'b1);
      end
    end else begin
      push_event(KIND_UNKNOWN, 8'h00, 1'b0, 1'b0, 1'b1);
    end
  endfunction

  function void predict_byte(logic [7:0] b);
    bit [3:0] n;
    code[held[2:0]] = b;
    held = held + 4'd1;
    n    = held;
    if (!in_e1 && !in_e0 && !in_prtsc && b == BYTE_E0) begin
      in_e0 = 1'b1;
      return;
    end
    if (!in_e1 && !in_e0 && !in_prtsc && b == BYTE_E1) begin
      in_e1 = 1'b1;
      return;
    end
    if (!in_break && b == BYTE_F0) begin
      in_break = 1'b1;
      return;
    end
    if (!in_prtsc && in_e0 && b == BYTE_PS_MK && !in_break) begin
      in_prtsc = 1'b1;
      return;
    end
    if (!in_prtsc && in_e0 && b == BYTE_PS_BK && in_break) begin
      in_prtsc = 1'b1;
      return;
    end
    // hold while a pause or print screen code is still incomplete
    if (in_e1 && n < LEN_PAUSE)
      return;
    if (in_prtsc && ((in_break && n < LEN_PS_BREAK) || (!in_break && n < LEN_PS_MAKE)))
      return;
    decode_code(n);
    held     = 4'd0;
    in_e0    = 1'b0;
    in_e1    = 1'b0;
    in_break = 1'b0;
    in_prtsc = 1'b0;
  endfunction

  task report(string msg);
    if (errors < 40)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  task check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      report($sformatf("event %0d %s: got %0h, want %0h", events_seen, name, got, want));
  endtask

  task check_event(event_t got);
    event_t want;
    events_seen++;
    if (due_events.size() == 0) begin
      report($sformatf("event %0d not expected: kind %0d byte %02h", events_seen,
                       got.key_kind, got.key_byte));
      return;
    end
    want = due_events.pop_front();
    check_field("key_kind", got.key_kind, want.key_kind);
    check_field("key_byte", got.key_byte, want.key_byte);
    check_field("pressed", got.pressed, want.pressed);
    check_field("lock_leds", got.lock_leds, want.lock_leds);
    check_field("leds_changed", got.leds_changed, want.leds_changed);
    check_field("last_of_run", got.last_of_run, want.last_of_run);
    if (want.key_kind == KIND_PAUSE && want.last_of_run)
      pauses_seen++;
    if (want.leds_changed)
      toggles_seen++;
  endtask
endclass

module tb_top;
  localparam int BYTE_TARGET = 950;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst;

  ps2dfr_scan_if  scan ();
  ps2dfr_event_if evt ();

  ps2_set2_scancode_deframer uut (
    .clk  (clk),
    .rst  (rst),
    .scan (scan),
    .evt  (evt)
  );

  key_event_board board;
  int             bytes_sent;
  int             cycles = 0;
  int             stall_left = 0;
  bit             calm;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15)
      return $urandom_range(1, 3);
    else if (r < 19)
      return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return BYTE_CAPS;
      1:       return BYTE_NUM;
      2:       return BYTE_SCRL;
      3:       return BYTE_ACK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // event sink: random stalls, none started while calm
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      evt.ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap() - 1;
      evt.ready  <= 1'b0;
    end else begin
      evt.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && evt.valid && evt.ready)
      board.check_event('{key_kind: key_kind_t'(evt.key_kind), key_byte: evt.key_byte,
                          pressed: evt.pressed, lock_leds: evt.lock_leds,
                          leds_changed: evt.leds_changed, last_of_run: evt.last_of_run});
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still due", cycles,
               board.due_events.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      scan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan.valid     <= 1'b1;
    scan.scan_byte <= b;
    do @(posedge clk); while (!scan.ready);
    board.predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_code(input logic [7:0] bytes[$]);
    foreach (bytes[i])
      send_byte(bytes[i]);
  endtask

  task automatic send_random_code();
    logic [7:0] q[$];
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      q = '{8'($urandom_range(0, 255))};
    end else if (pick < 35) begin
      q = '{BYTE_F0, pick_key()};
    end else if (pick < 45) begin
      q = '{BYTE_E0, 8'($urandom_range(0, 255))};
    end else if (pick < 55) begin
      q = '{BYTE_E0, BYTE_F0, 8'($urandom_range(0, 255))};
    end else if (pick < 60) begin
      q = '{BYTE_E0, BYTE_PS_MK, BYTE_E0, BYTE_PS_BK};
    end else if (pick < 65) begin
      q = '{BYTE_E0, BYTE_F0, BYTE_PS_BK, BYTE_E0, BYTE_F0, BYTE_PS_MK};
    end else if (pick < 70) begin
      q = '{BYTE_E1, 8'h14, 8'h77, BYTE_E1, BYTE_F0, 8'h14, BYTE_F0, 8'h77};
    end else if (pick < 75) begin
      // late release prefix pushes an E1 code past eight bytes
      q = '{BYTE_E1};
      repeat (6) q.push_back(8'($urandom_range(0, 255)));
      q.push_back(BYTE_F0);
      q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      q = '{pick_key()};
    end else begin
      repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
    end
    send_code(q);
  endtask

  initial begin
    board          = new();
    bytes_sent     = 0;
    calm           = 1'b0;
    rst            <= 1'b1;
    scan.valid     <= 1'b0;
    scan.scan_byte <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, acks, lock toggles, extended, print screen, pause
    send_code('{8'h00, 8'hFF, BYTE_ACK, BYTE_F0, BYTE_ACK});
    send_code('{BYTE_F0, BYTE_CAPS, BYTE_F0, BYTE_NUM, BYTE_F0, BYTE_SCRL});
    send_code('{BYTE_E0, 8'h75, BYTE_E0, BYTE_F0, 8'h75});
    send_code('{BYTE_E0, BYTE_PS_MK, BYTE_E0, BYTE_PS_BK});
    send_code('{BYTE_E1, 8'h14, 8'h77, BYTE_E1, BYTE_F0, 8'h14, BYTE_F0, 8'h77});

    while (bytes_sent < BYTE_TARGET) begin
      // alternate stretches with and without idle cycles
      calm = ((bytes_sent / 150) % 3 == 1);
      send_random_code();
    end
    calm = 1'b0;
    scan.valid <= 1'b0;

    while (board.due_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d scan bytes; checked %0d key events, %0d pauses, %0d lock toggles.",
             bytes_sent, board.events_seen, board.pauses_seen, board.toggles_seen);
    $display("Mismatches: %0d", board.errors);
    if (board.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

[sim.f]
rtl/core/ps2dfr_pkg.sv
rtl/core/ps2dfr_if.sv
rtl/core/ps2dfr_decode.sv
rtl/core/ps2_set2_scancode_deframer.sv
tb/sv/tb_top.sv
